// ----- hw/rtl/cdd_pkg.sv -----
// Types, constants and calendar helpers shared by the date decrement block.
package cdd_pkg;

   localparam int CMD_W   = 3;
   localparam int COUNT_W = 15;
   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 16;

   // Working year reaches -32768 - 32767*1000, which fits in 27 bits signed.
   localparam int WIDE_W  = 27;
   localparam int SCALE_W = 10;
   localparam int PROD_W  = COUNT_W + SCALE_W;
   localparam int STEPS_W = 20;
   localparam int REM_W   = 17;
   localparam int R400_W  = 9;

   localparam logic [CMD_W-1:0] CMD_DAY        = 3'd0;
   localparam logic [CMD_W-1:0] CMD_WEEK       = 3'd1;
   localparam logic [CMD_W-1:0] CMD_MONTH      = 3'd2;
   localparam logic [CMD_W-1:0] CMD_YEAR       = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DECADE     = 3'd4;
   localparam logic [CMD_W-1:0] CMD_CENTURY    = 3'd5;
   localparam logic [CMD_W-1:0] CMD_MILLENNIUM = 3'd6;

   localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
   localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
   localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;

   localparam logic [DAY_W-1:0] DAY_FIRST = 5'd1;
   localparam logic [DAY_W-1:0] DAY_31    = 5'd31;

   // Bias that lifts any 16-bit year to a non-negative multiple-of-400 offset.
   localparam logic signed [WIDE_W-1:0] YEAR_BIAS_NEG = -27'sd32800;
   localparam logic [WIDE_W-1:0]        CYCLE_400     = 27'd400;
   localparam logic [R400_W-1:0]        R400_LAST     = 9'd399;
   localparam logic signed [WIDE_W-1:0] YEAR_MIN      = -27'sd32768;

   typedef struct packed {
      logic signed [WIDE_W-1:0] diff;
      logic                     neg;
   } alu_res_type;

   function automatic logic [SCALE_W-1:0] unit_scale(input logic [CMD_W-1:0] cmd);
      logic [SCALE_W-1:0] s;
      unique case (cmd)
         CMD_DAY:        s = 10'd1;
         CMD_WEEK:       s = 10'd7;
         CMD_MONTH:      s = 10'd30;
         CMD_YEAR:       s = 10'd1;
         CMD_DECADE:     s = 10'd10;
         CMD_CENTURY:    s = 10'd100;
         CMD_MILLENNIUM: s = 10'd1000;
         default:        s = 10'd0;
      endcase
      return s;
   endfunction

   function automatic logic is_day_unit(input logic [CMD_W-1:0] cmd);
      return (cmd == CMD_DAY) || (cmd == CMD_WEEK) || (cmd == CMD_MONTH);
   endfunction

   // r is the year modulo 400, taken non-negative.
   function automatic logic is_leap(input logic [R400_W-1:0] r);
      return (r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
   endfunction

   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic [R400_W-1:0] r);
      logic [DAY_W-1:0] d;
      unique case (m)
         4'd2:                    d = is_leap(r) ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
         default:                 d = 5'd31;
      endcase
      return d;
   endfunction

endpackage

// ----- hw/rtl/cdd_if.sv -----
// Request and response channel interfaces of the date decrement block.
interface cdd_req_if import cdd_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CMD_W-1:0]          cmd;
   logic [COUNT_W-1:0]        count;
   logic [DAY_W-1:0]          day_in;
   logic [MONTH_W-1:0]        month_in;
   logic signed [YEAR_W-1:0]  year_in;

   modport source (output valid, cmd, count, day_in, month_in, year_in, input ready);
   modport sink   (input valid, cmd, count, day_in, month_in, year_in, output ready);
endinterface

interface cdd_rsp_if import cdd_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [DAY_W-1:0]          day_out;
   logic [MONTH_W-1:0]        month_out;
   logic signed [YEAR_W-1:0]  year_out;
   logic                      year_clipped;

   modport source (output valid, day_out, month_out, year_out, year_clipped, input ready);
   modport sink   (input valid, day_out, month_out, year_out, year_clipped, output ready);
endinterface

// ----- hw/rtl/cdd_alu.sv -----
// Shared subtract-and-compare unit used by every step of the sequencer.
module cdd_alu import cdd_pkg::*; (
   input  logic signed [WIDE_W-1:0] op_a,
   input  logic signed [WIDE_W-1:0] op_b,
   output alu_res_type              res
);

   always_comb begin
      res.diff = op_a - op_b;
      res.neg  = res.diff[WIDE_W-1];
   end

endmodule

// ----- hw/rtl/calendar_date_decrement_top.sv -----
// Top level of the date decrement block: sequencer around the shared subtractor.
//
// Moves a Gregorian date back by a count of days, weeks, 30-day months, years,
// decades, centuries or millennia, one item at a time; req ready is low while an
// item is in work. Year units pass through the scale multiply, one subtract and
// the result load. Day units pass through the scale multiply, a restoring
// reduction of the year modulo 400 for the leap rule, the walk, in which the
// shared subtractor either removes the remaining days or drops to the last day
// of the previous month each cycle, a last walk step that finds no days left,
// and the result load. A finished response waits in the output register, and
// the next item is taken while it waits; while the output register is still
// full, the sequencer holds the finished item in its last state.
module calendar_date_decrement_top import cdd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   cdd_req_if.sink   req_if,
   cdd_rsp_if.source rsp_if
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_MOD  = 3'd2;
   localparam logic [2:0] ST_WALK = 3'd3;
   localparam logic [2:0] ST_YEAR = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0]               state_ff, state_in;
   logic [2:0]               k_ff, k_in;
   logic [CMD_W-1:0]         cmd_ff, cmd_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic [DAY_W-1:0]         day_ff, day_in;
   logic [MONTH_W-1:0]       month_ff, month_in;
   logic signed [WIDE_W-1:0] year_ff, year_in;
   logic [STEPS_W-1:0]       steps_ff, steps_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DAY_W-1:0]         rsp_day_ff, rsp_day_in;
   logic [MONTH_W-1:0]       rsp_month_ff, rsp_month_in;
   logic signed [YEAR_W-1:0] rsp_year_ff, rsp_year_in;
   logic                     rsp_clip_ff, rsp_clip_in;

   logic signed [WIDE_W-1:0] alu_a, alu_b;
   alu_res_type              alu_res;
   logic                     req_fire;
   logic                     rsp_free;
   logic                     clip;
   logic [R400_W-1:0]        r400;
   logic [MONTH_W-1:0]       month_prev;

   cdd_alu u_alu (
      .op_a (alu_a),
      .op_b (alu_b),
      .res  (alu_res)
   );

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;
   assign clip         = (year_ff < YEAR_MIN);
   assign r400         = rem_ff[R400_W-1:0];
   assign month_prev   = month_ff - 4'd1;

   // Operand select for the shared subtractor.
   always_comb begin
      unique case (state_ff)
         ST_MUL: begin
            alu_a = year_ff;
            alu_b = YEAR_BIAS_NEG;
         end
         ST_MOD: begin
            alu_a = signed'(WIDE_W'(rem_ff));
            alu_b = signed'(CYCLE_400 << k_ff);
         end
         ST_WALK: begin
            alu_a = signed'(WIDE_W'(steps_ff));
            alu_b = signed'(WIDE_W'(day_ff));
         end
         ST_YEAR: begin
            alu_a = year_ff;
            alu_b = signed'(WIDE_W'(prod_ff));
         end
         default: begin
            alu_a = '0;
            alu_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      cmd_in       = cmd_ff;
      count_in     = count_ff;
      day_in       = day_ff;
      month_in     = month_ff;
      year_in      = year_ff;
      steps_in     = steps_ff;
      rem_in       = rem_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_day_in   = rsp_day_ff;
      rsp_month_in = rsp_month_ff;
      rsp_year_in  = rsp_year_ff;
      rsp_clip_in  = rsp_clip_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in   = req_if.cmd;
               count_in = req_if.count;
               day_in   = (req_if.day_in == '0) ? DAY_FIRST : req_if.day_in;
               if (req_if.month_in == '0) begin
                  month_in = JANUARY;
               end else if (req_if.month_in > DECEMBER) begin
                  month_in = DECEMBER;
               end else begin
                  month_in = req_if.month_in;
               end
               year_in  = WIDE_W'(req_if.year_in);
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(count_ff) * PROD_W'(unit_scale(cmd_ff));
            steps_in = prod_in[STEPS_W-1:0];
            rem_in   = alu_res.diff[REM_W-1:0];
            k_in     = 3'd7;
            state_in = is_day_unit(cmd_ff) ? ST_MOD : ST_YEAR;
         end
         ST_MOD: begin
            // Restoring reduction: keep the difference where it stays non-negative.
            if (!alu_res.neg) begin
               rem_in = alu_res.diff[REM_W-1:0];
            end
            k_in = k_ff - 3'd1;
            if (k_ff == 3'd0) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (steps_ff == '0) begin
               state_in = ST_DONE;
            end else if (alu_res.neg) begin
               // Remaining days fit inside this month.
               day_in   = DAY_W'(-alu_res.diff);
               steps_in = '0;
            end else begin
               // Drop to the last day of the previous month.
               steps_in = alu_res.diff[STEPS_W-1:0];
               if (month_ff == JANUARY) begin
                  month_in = DECEMBER;
                  day_in   = DAY_31;
                  year_in  = year_ff - WIDE_W'(1);
                  rem_in   = REM_W'((r400 == '0) ? R400_LAST : r400 - 9'd1);
               end else begin
                  month_in = month_prev;
                  day_in   = month_days(month_prev, r400);
               end
            end
         end
         ST_YEAR: begin
            year_in  = alu_res.diff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_day_in   = day_ff;
               rsp_month_in = month_ff;
               rsp_year_in  = clip ? YEAR_MIN[YEAR_W-1:0] : year_ff[YEAR_W-1:0];
               rsp_clip_in  = clip;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      cmd_ff       <= cmd_in;
      count_ff     <= count_in;
      day_ff       <= day_in;
      month_ff     <= month_in;
      year_ff      <= year_in;
      steps_ff     <= steps_in;
      rem_ff       <= rem_in;
      prod_ff      <= prod_in;
      rsp_day_ff   <= rsp_day_in;
      rsp_month_ff <= rsp_month_in;
      rsp_year_ff  <= rsp_year_in;
      rsp_clip_ff  <= rsp_clip_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.day_out      = rsp_day_ff;
   assign rsp_if.month_out    = rsp_month_ff;
   assign rsp_if.year_out     = rsp_year_ff;
   assign rsp_if.year_clipped = rsp_clip_ff;

endmodule

// ----- hw/rtl/cdd_checker.sv -----
// Port-level checks of the date decrement block, bound to the top level.
module cdd_checker import cdd_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [DAY_W-1:0]         day_out,
   input logic [MONTH_W-1:0]       month_out,
   input logic signed [YEAR_W-1:0] year_out,
   input logic                     year_clipped
);

   // The block holds one item at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous item in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(day_out) && $stable(month_out)
         && $stable(year_out) && $stable(year_clipped))
      else $error("stalled response changed");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> day_out != '0 && month_out != '0 && month_out <= DECEMBER)
      else $error("response date out of range");

   a_clip_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && year_clipped |-> year_out == YEAR_MIN[YEAR_W-1:0])
      else $error("clipped year not saturated");

endmodule

bind calendar_date_decrement_top cdd_checker u_cdd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .day_out      (rsp_if.day_out),
   .month_out    (rsp_if.month_out),
   .year_out     (rsp_if.year_out),
   .year_clipped (rsp_if.year_clipped)
);
